// ===== rtl/core/srsp_pkg.sv =====
// ---------------------------------------------------------------------------
// srsp_pkg: shared types and constants for the row segment planner
// Widths, register codes, segment and plan records, queue sizing.
// ---------------------------------------------------------------------------
package srsp_pkg;

  localparam int OUT_WIDTH = 4096;
  localparam int CFG_AW    = 5;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  // sample-domain working values all fit in 32 bits signed
  typedef logic signed [31:0] samp_t;

  localparam samp_t OUT_WIDTH_S = samp_t'(OUT_WIDTH);

  typedef enum logic [2:0] {
    CFG_EQUATOR_WIDTH = 3'd0,
    CFG_SHIFT         = 3'd1,
    CFG_OUT_LEFT      = 3'd2,
    CFG_OUT_SPAN      = 3'd3,
    CFG_IN_LEFT       = 3'd4,
    CFG_IN_SPAN       = 3'd5,
    CFG_OUT_CENTER    = 3'd6,
    CFG_IN_CENTER     = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PLAN_EMPTY,
    PLAN_INSIDE,
    PLAN_COVER,
    PLAN_WRAP_HI,
    PLAN_WRAP_LO
  } plan_kind_t;

  typedef struct packed {
    logic        [30:0] equator_width_px;
    logic signed [31:0] shift_px;
    logic signed [31:0] out_left_px;
    logic        [30:0] out_span_px;
    logic signed [31:0] in_left_px;
    logic        [30:0] in_span_px;
    logic signed [20:0] out_center_sample;
    logic signed [20:0] in_center_sample;
  } cfg_t;

  typedef struct packed {
    logic signed [20:0] src;
    logic        [15:0] cnt;
    logic        [15:0] dst;
  } seg_t;

  typedef struct packed {
    seg_t seg0;
    seg_t seg1;
    logic two;
  } plan_t;

endpackage

// ===== rtl/core/srsp_cfg.sv =====
// ---------------------------------------------------------------------------
// srsp_cfg: configuration register file
// APB-style write and read access to the eight planner registers.
// ---------------------------------------------------------------------------
module srsp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srsp_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output srsp_pkg::cfg_t               cfg
);
  import srsp_pkg::*;

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx    = cfg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        CFG_EQUATOR_WIDTH: cfg_r.equator_width_px  <= pwdata[30:0];
        CFG_SHIFT:         cfg_r.shift_px          <= pwdata;
        CFG_OUT_LEFT:      cfg_r.out_left_px       <= pwdata;
        CFG_OUT_SPAN:      cfg_r.out_span_px       <= pwdata[30:0];
        CFG_IN_LEFT:       cfg_r.in_left_px        <= pwdata;
        CFG_IN_SPAN:       cfg_r.in_span_px        <= pwdata[30:0];
        CFG_OUT_CENTER:    cfg_r.out_center_sample <= pwdata[20:0];
        CFG_IN_CENTER:     cfg_r.in_center_sample  <= pwdata[20:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_EQUATOR_WIDTH: prdata = {1'b0, cfg_r.equator_width_px};
      CFG_SHIFT:         prdata = cfg_r.shift_px;
      CFG_OUT_LEFT:      prdata = cfg_r.out_left_px;
      CFG_OUT_SPAN:      prdata = {1'b0, cfg_r.out_span_px};
      CFG_IN_LEFT:       prdata = cfg_r.in_left_px;
      CFG_IN_SPAN:       prdata = {1'b0, cfg_r.in_span_px};
      CFG_OUT_CENTER:    prdata = {11'b0, cfg_r.out_center_sample};
      CFG_IN_CENTER:     prdata = {11'b0, cfg_r.in_center_sample};
    endcase
  end

endmodule

// ===== rtl/core/srsp_front.sv =====
// ---------------------------------------------------------------------------
// srsp_front: row geometry pipeline
// Seven stages: products, edge truncation, clipping, window placement,
// classification, segment candidates; packs a plan for the queue.
// ---------------------------------------------------------------------------
module srsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  srsp_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [16:0]         in_cos_lat,
  input  logic                q_full,
  output logic                q_push,
  output srsp_pkg::plan_t     q_data
);
  import srsp_pkg::*;

  typedef struct packed {
    samp_t src;
    samp_t cnt;
    samp_t dst;
    logic  pres;
  } cand_t;

  localparam logic        [48:0] HALF_U = 49'd8388608;
  localparam logic signed [49:0] HALF_S = 50'sd8388608;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  assign adv      = !(v7_r && q_full);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <= '0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // stage 1: the six products of the row cosine
  logic signed [17:0] c_s;
  logic        [47:0] eq_p_r, os_p_r, is_p_r;
  logic signed [48:0] sh_p_r, ol_p_r, il_p_r;

  assign c_s = {1'b0, in_cos_lat};

  always_ff @(posedge clk) begin
    if (adv) begin
      eq_p_r <= 48'(cfg.equator_width_px) * 48'(in_cos_lat);
      os_p_r <= 48'(cfg.out_span_px) * 48'(in_cos_lat);
      is_p_r <= 48'(cfg.in_span_px) * 48'(in_cos_lat);
      sh_p_r <= cfg.shift_px * c_s;
      ol_p_r <= cfg.out_left_px * c_s;
      il_p_r <= cfg.in_left_px * c_s;
    end
  end

  // stage 2: left edges truncated toward zero, wrap width, rounding bias
  samp_t              q_so, q_si, ss_o_n, ss_i_n, w_n;
  logic        [48:0] xs_o_n, xs_i_n;
  logic signed [49:0] t_n;
  samp_t              ss_o2_r, ss_i2_r, w2_r;
  logic        [48:0] xs_o2_r, xs_i2_r;
  logic signed [49:0] t2_r;

  always_comb begin
    q_so   = samp_t'(cfg.out_center_sample) + 1 + samp_t'(ol_p_r >>> 24);
    q_si   = samp_t'(cfg.in_center_sample) + 1 + samp_t'(il_p_r >>> 24);
    ss_o_n = (q_so < 0 && ol_p_r[23:0] != '0) ? q_so + 1 : q_so;
    ss_i_n = (q_si < 0 && il_p_r[23:0] != '0) ? q_si + 1 : q_si;
    xs_o_n = 49'(os_p_r) + HALF_U;
    xs_i_n = 49'(is_p_r) + HALF_U;
    w_n    = (eq_p_r[47:24] == '0) ? samp_t'(1) : samp_t'(eq_p_r[47:24]);
    // half away from zero
    t_n    = sh_p_r[48] ? 50'(sh_p_r) - HALF_S : 50'(sh_p_r) + HALF_S;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_o2_r <= ss_o_n;
      ss_i2_r <= ss_i_n;
      xs_o2_r <= xs_o_n;
      xs_i2_r <= xs_i_n;
      w2_r    <= w_n;
      t2_r    <= t_n;
    end
  end

  // stage 3: right edges and recentering shift
  samp_t q_eo, q_ei, q_off, es_o_n, es_i_n, off_n;
  samp_t ss_o3_r, es_o3_r, ss_i3_r, es_i3_r, w3_r, off3_r;

  always_comb begin
    q_eo  = ss_o2_r + samp_t'(xs_o2_r[48:24]);
    q_ei  = ss_i2_r + samp_t'(xs_i2_r[48:24]);
    q_off = samp_t'(t2_r >>> 24);
    if (w2_r == 1) begin
      es_o_n = ss_o2_r;
      es_i_n = ss_i2_r;
    end else begin
      es_o_n = (q_eo < 0 && xs_o2_r[23:0] != '0) ? q_eo + 1 : q_eo;
      es_i_n = (q_ei < 0 && xs_i2_r[23:0] != '0) ? q_ei + 1 : q_ei;
    end
    off_n = (t2_r < 0 && t2_r[23:0] != '0) ? q_off + 1 : q_off;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_o3_r <= ss_o2_r;
      es_o3_r <= es_o_n;
      ss_i3_r <= ss_i2_r;
      es_i3_r <= es_i_n;
      w3_r    <= w2_r;
      off3_r  <= off_n;
    end
  end

  // stage 4: clip output edges to the row
  logic  out_win;
  samp_t ss_c, es_c, ns_n, base_n;
  samp_t ss_o4_r, es_o4_r, ns_o4_r, base4_r, ss_i4_r, es_i4_r, w4_r;

  always_comb begin
    out_win = (ss_o3_r < 1 && es_o3_r < 1) ||
              (ss_o3_r > OUT_WIDTH_S && es_o3_r > OUT_WIDTH_S);
    if (out_win) begin
      ss_c = samp_t'(1);
      es_c = samp_t'(1);
    end else begin
      ss_c = (ss_o3_r < 1) ? samp_t'(1) : ss_o3_r;
      es_c = (es_o3_r > OUT_WIDTH_S) ? OUT_WIDTH_S : es_o3_r;
    end
    ns_n   = out_win ? samp_t'(0) : es_c - ss_c + 1;
    base_n = samp_t'(cfg.in_center_sample) - samp_t'(cfg.out_center_sample) + off3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_o4_r <= ss_c;
      es_o4_r <= es_c;
      ns_o4_r <= ns_n;
      base4_r <= base_n;
      ss_i4_r <= ss_i3_r;
      es_i4_r <= es_i3_r;
      w4_r    <= w3_r;
    end
  end

  // stage 5: output window in input numbering
  samp_t ss_oi5_r, es_oi5_r, ss_o5_r, es_o5_r, ns_o5_r, ss_i5_r, es_i5_r, w5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_oi5_r <= base4_r + ss_o4_r;
      es_oi5_r <= base4_r + ss_o4_r + ns_o4_r - 1;
      ss_o5_r  <= ss_o4_r;
      es_o5_r  <= es_o4_r;
      ns_o5_r  <= ns_o4_r;
      ss_i5_r  <= ss_i4_r;
      es_i5_r  <= es_i4_r;
      w5_r     <= w4_r;
    end
  end

  // stage 6: classify and move the window across the wrap
  plan_kind_t kind_n;
  logic       hi_first, lo_first;
  samp_t      sh_ss_n, sh_es_n;
  plan_kind_t kind6_r;
  logic       first6_r;
  samp_t      sh_ss6_r, sh_es6_r, ss_oi6_r, es_oi6_r, ss_o6_r, es_o6_r, ns_o6_r;
  samp_t      ss_i6_r, es_i6_r;

  always_comb begin
    priority if (ns_o5_r <= 0) begin
      kind_n = PLAN_EMPTY;
    end else if (ss_oi5_r >= ss_i5_r && es_oi5_r <= es_i5_r) begin
      kind_n = PLAN_INSIDE;
    end else if (ss_oi5_r <= ss_i5_r && es_oi5_r >= es_i5_r) begin
      kind_n = PLAN_COVER;
    end else if (es_oi5_r > es_i5_r) begin
      kind_n = PLAN_WRAP_HI;
    end else begin
      kind_n = PLAN_WRAP_LO;
    end
    hi_first = ss_oi5_r <= es_i5_r;
    lo_first = es_oi5_r >= ss_i5_r;
    if (kind_n == PLAN_WRAP_HI) begin
      sh_ss_n = (hi_first ? es_i5_r + 1 : ss_oi5_r) - w5_r;
      sh_es_n = es_oi5_r - w5_r;
    end else begin
      sh_ss_n = ss_oi5_r + w5_r;
      sh_es_n = (lo_first ? ss_i5_r - 1 : es_oi5_r) + w5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind6_r  <= kind_n;
      first6_r <= (kind_n == PLAN_WRAP_HI) ? hi_first : lo_first;
      sh_ss6_r <= sh_ss_n;
      sh_es6_r <= sh_es_n;
      ss_oi6_r <= ss_oi5_r;
      es_oi6_r <= es_oi5_r;
      ss_o6_r  <= ss_o5_r;
      es_o6_r  <= es_o5_r;
      ns_o6_r  <= ns_o5_r;
      ss_i6_r  <= ss_i5_r;
      es_i6_r  <= es_i5_r;
    end
  end

  // stage 7: first and second segment candidates
  cand_t a_n, b_n, a7_r, b7_r;
  samp_t ss2, es2;

  always_comb begin
    a_n = '0;
    b_n = '0;
    ss2 = (sh_ss6_r < ss_i6_r) ? ss_i6_r : sh_ss6_r;
    es2 = (sh_es6_r > es_i6_r) ? es_i6_r : sh_es6_r;
    unique case (kind6_r)
      PLAN_EMPTY: begin
      end
      PLAN_INSIDE: begin
        a_n = '{src: ss_oi6_r, cnt: ns_o6_r, dst: ss_o6_r - 1, pres: 1'b1};
      end
      PLAN_COVER: begin
        a_n = '{src: ss_i6_r, cnt: es_i6_r - ss_i6_r + 1,
                dst: ss_o6_r - 1 + ss_i6_r - ss_oi6_r, pres: 1'b1};
      end
      PLAN_WRAP_HI: begin
        a_n = '{src: ss_oi6_r, cnt: es_i6_r - ss_oi6_r + 1,
                dst: ss_o6_r - 1, pres: first6_r};
        b_n = '{src: ss2, cnt: sh_es6_r - ss2 + 1, dst: es_o6_r - sh_es6_r + ss2 - 1,
                pres: sh_es6_r >= ss_i6_r && sh_es6_r < es_i6_r};
      end
      PLAN_WRAP_LO: begin
        a_n = '{src: ss_i6_r, cnt: es_oi6_r - ss_i6_r + 1,
                dst: es_o6_r - es_oi6_r + ss_i6_r - 1, pres: first6_r};
        b_n = '{src: sh_ss6_r, cnt: es2 - sh_ss6_r + 1, dst: ss_o6_r - 1,
                pres: sh_ss6_r <= es_i6_r && sh_ss6_r > ss_i6_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a7_r <= a_n;
      b7_r <= b_n;
    end
  end

  // drop segments with no samples, pack the plan
  logic va, vb;
  seg_t sa, sb;

  always_comb begin
    va = a7_r.pres && a7_r.cnt > 0;
    vb = b7_r.pres && b7_r.cnt > 0;
    sa = '{src: a7_r.src[20:0], cnt: a7_r.cnt[15:0], dst: a7_r.dst[15:0]};
    sb = '{src: b7_r.src[20:0], cnt: b7_r.cnt[15:0], dst: b7_r.dst[15:0]};
    q_data = '0;
    priority if (va && vb) begin
      q_data.seg0 = sa;
      q_data.seg1 = sb;
      q_data.two  = 1'b1;
    end else if (va) begin
      q_data.seg0 = sa;
    end else if (vb) begin
      q_data.seg0 = sb;
    end else begin
      q_data.seg0 = '0;
    end
  end

  assign q_push = v7_r && adv;

endmodule

// ===== rtl/core/srsp_queue.sv =====
// ---------------------------------------------------------------------------
// srsp_queue: plan queue
// Small first-in first-out buffer between the geometry pipeline and the
// segment emitter.
// ---------------------------------------------------------------------------
module srsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srsp_pkg::plan_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output srsp_pkg::plan_t head
);
  import srsp_pkg::*;

  plan_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign full  = cnt_r == Q_CW'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/srsp_back.sv =====
// ---------------------------------------------------------------------------
// srsp_back: segment emitter
// Walks the one or two segments of the head plan into the output register.
// ---------------------------------------------------------------------------
module srsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  srsp_pkg::plan_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] out_src_sample,
  output logic [15:0]        out_copy_count,
  output logic [15:0]        out_dst_offset,
  output logic               out_last_segment
);
  import srsp_pkg::*;

  logic valid_r, valid_nxt;
  logic sel_r, sel_nxt;
  seg_t seg_r;
  logic last_r;
  logic load, last;
  seg_t seg;

  always_comb begin
    load      = (!valid_r || out_ready) && !q_empty;
    seg       = sel_r ? q_head.seg1 : q_head.seg0;
    last      = sel_r || !q_head.two;
    q_pop     = load && last;
    sel_nxt   = load ? !last : sel_r;
    valid_nxt = load ? 1'b1 : (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_r  <= seg;
      last_r <= last;
    end
  end

  assign out_valid        = valid_r;
  assign out_src_sample   = seg_r.src;
  assign out_copy_count   = seg_r.cnt;
  assign out_dst_offset   = seg_r.dst;
  assign out_last_segment = last_r;

endmodule

// ===== rtl/core/sinusoidal_row_segment_planner.sv =====
// ---------------------------------------------------------------------------
// sinusoidal_row_segment_planner: recentering copy plan per map row
// An accepted row passes the front pipeline, the plan queue and the output
// register before its first segment. One row is taken per cycle unless a
// finished plan meets a full four-entry queue; a row split at the wrap
// gives two segments. Synchronous active-low reset empties the pipeline
// and queue and clears the configuration registers to zero.
// ---------------------------------------------------------------------------
module sinusoidal_row_segment_planner (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [16:0]                 in_cos_lat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [20:0]          out_src_sample,
  output logic [15:0]                 out_copy_count,
  output logic [15:0]                 out_dst_offset,
  output logic                        out_last_segment,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import srsp_pkg::*;

  cfg_t  cfg;
  logic  q_full, q_empty, q_push, q_pop;
  plan_t q_data, q_head;

  srsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cos_lat (in_cos_lat),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  srsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  srsp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_src_sample   (out_src_sample),
    .out_copy_count   (out_copy_count),
    .out_dst_offset   (out_dst_offset),
    .out_last_segment (out_last_segment)
  );

endmodule

// ===== verif/sinusoidal_row_segment_planner_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sinusoidal_row_segment_planner_tb: self-checking bench for the row planner
// Rows of latitude cosine go in with bursty timing while the segment side
// stalls on shifting patterns. An in-bench predictor plans every accepted row
// and each segment that comes out is checked against the oldest plan.
// Register settings cover reset values, wrap in both directions, full cover,
// rows off the map, range extremes and random maps.
// ---------------------------------------------------------------------------
module sinusoidal_row_segment_planner_tb;
  import srsp_pkg::*;

  localparam int     RESET_CYCLES   = 12;
  localparam int     SETTLE_CYCLES  = 24;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     RANDOM_ROWS    = 1100;
  localparam int     RANDOM_PHASES  = 10;
  localparam longint ONE_Q24        = 64'sd16777216;
  localparam longint HALF_Q24       = 64'sd8388608;
  localparam longint OUT_LIMIT      = longint'(OUT_WIDTH);

  typedef struct packed {
    seg_t seg;
    logic last;
  } row_seg_t;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_MOSTLY,
    READY_BLOCKS
  } ready_pattern_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [16:0]          in_cos_lat = '0;
  logic                 out_ready  = 1'b0;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [CFG_AW-1:0]    paddr      = '0;
  logic [31:0]          pwdata     = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic signed [20:0]   out_src_sample;
  logic [15:0]          out_copy_count;
  logic [15:0]          out_dst_offset;
  logic                 out_last_segment;
  logic [31:0]          prdata;
  logic                 pready;

  cfg_t           row_cfg = '0;
  logic [31:0]    cfg_words [8];
  row_seg_t       planned_segs [$];
  int             errors      = 0;
  int             burst_left  = 0;
  bit             gaps_on     = 1'b1;
  int             idle_cycles = 0;
  ready_pattern_t ready_mode  = READY_ALWAYS;
  int             mode_left   = 0;

  sinusoidal_row_segment_planner u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cos_lat       (in_cos_lat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_src_sample   (out_src_sample),
    .out_copy_count   (out_copy_count),
    .out_dst_offset   (out_dst_offset),
    .out_last_segment (out_last_segment),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint q24_trunc(input longint v);
    if (v >= 0) return v >>> 24;
    return -((-v) >>> 24);
  endfunction

  function automatic longint q24_round_away(input longint v);
    if (v >= 0) return (v + HALF_Q24) >>> 24;
    return -(((-v) + HALF_Q24) >>> 24);
  endfunction

  // works out the copy plan of one row and queues its segments
  function automatic void plan_row_segments(input logic [16:0] cos_q);
    longint   c, oc, ic, w, off, n;
    longint   ss_o, es_o, ns_o, ss_i, es_i, ss_oi, es_oi;
    longint   src [2];
    longint   cnt [2];
    longint   dst [2];
    int       k, m, i;
    row_seg_t seg;
    c   = cos_q;
    oc  = $signed(row_cfg.out_center_sample);
    ic  = $signed(row_cfg.in_center_sample);
    w   = (longint'(row_cfg.equator_width_px) * c) >>> 24;
    if (w == 0) w = 1;
    off = q24_round_away(longint'($signed(row_cfg.shift_px)) * c);

    ss_o = q24_trunc((oc + 1) * ONE_Q24 + longint'($signed(row_cfg.out_left_px)) * c);
    es_o = q24_trunc(ss_o * ONE_Q24 + longint'(row_cfg.out_span_px) * c + HALF_Q24);
    if (w == 1) es_o = ss_o;
    ns_o = es_o - ss_o + 1;
    // row wholly off the output
    if ((ss_o < 1 && es_o < 1) || (ss_o > OUT_LIMIT && es_o > OUT_LIMIT)) begin
      ss_o = 1;
      es_o = 1;
      ns_o = 0;
    end
    if (ss_o < 1) begin
      ss_o = 1;
      ns_o = es_o - ss_o + 1;
    end
    if (es_o > OUT_LIMIT) begin
      es_o = OUT_LIMIT;
      ns_o = es_o - ss_o + 1;
    end

    ss_oi = ic + off - oc + ss_o;
    es_oi = ss_oi + ns_o - 1;
    ss_i  = q24_trunc((ic + 1) * ONE_Q24 + longint'($signed(row_cfg.in_left_px)) * c);
    es_i  = q24_trunc(ss_i * ONE_Q24 + longint'(row_cfg.in_span_px) * c + HALF_Q24);
    if (w == 1) es_i = ss_i;

    k = 0;
    if (ns_o > 0) begin
      if (ss_oi >= ss_i && es_oi <= es_i) begin
        src[k] = ss_oi; cnt[k] = ns_o; dst[k] = ss_o - 1; k++;
      end else if (ss_oi <= ss_i && es_oi >= es_i) begin
        src[k] = ss_i; cnt[k] = es_i - ss_i + 1; dst[k] = ss_o - 1 + (ss_i - ss_oi); k++;
      end else if (es_oi > es_i) begin
        // window runs off the right edge, the rest wraps back by one row width
        if (ss_oi <= es_i) begin
          src[k] = ss_oi; cnt[k] = es_i - ss_oi + 1; dst[k] = ss_o - 1; k++;
          ss_oi = es_i + 1;
        end
        ss_oi -= w;
        es_oi -= w;
        if (es_oi >= ss_i && es_oi < es_i) begin
          if (ss_oi < ss_i) ss_oi = ss_i;
          n = es_oi - ss_oi + 1;
          src[k] = ss_oi; cnt[k] = n; dst[k] = es_o - n; k++;
        end
      end else if (ss_oi < ss_i) begin
        if (es_oi >= ss_i) begin
          n = es_oi - ss_i + 1;
          src[k] = ss_i; cnt[k] = n; dst[k] = es_o - n; k++;
          es_oi = ss_i - 1;
        end
        ss_oi += w;
        es_oi += w;
        if (ss_oi <= es_i && ss_oi > ss_i) begin
          if (es_oi > es_i) es_oi = es_i;
          src[k] = ss_oi; cnt[k] = es_oi - ss_oi + 1; dst[k] = ss_o - 1; k++;
        end
      end
    end

    m = 0;
    for (i = 0; i < k; i++) begin
      if (cnt[i] > 0) begin
        src[m] = src[i];
        cnt[m] = cnt[i];
        dst[m] = dst[i];
        m++;
      end
    end
    if (m == 0) begin
      seg = '0;
      seg.last = 1'b1;
      planned_segs.push_back(seg);
    end
    for (i = 0; i < m; i++) begin
      seg.seg.src = 21'(src[i]);
      seg.seg.cnt = 16'(cnt[i]);
      seg.seg.dst = 16'(dst[i]);
      seg.last    = (i == m - 1);
      planned_segs.push_back(seg);
    end
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : seg_monitor
    row_seg_t got, want;
    if (rst_n && in_valid && in_ready) plan_row_segments(in_cos_lat);
    if (rst_n && out_valid && out_ready) begin
      got.seg.src = out_src_sample;
      got.seg.cnt = out_copy_count;
      got.seg.dst = out_dst_offset;
      got.last    = out_last_segment;
      if (planned_segs.size() == 0) begin
        errors++;
        $display("%0t: segment with none expected, src %0d count %0d offset %0d last %0b",
                 $time, got.seg.src, got.seg.cnt, got.seg.dst, got.last);
      end else begin
        want = planned_segs.pop_front();
        check_field("src_sample", 32'(want.seg.src), 32'(got.seg.src));
        check_field("copy_count", 32'(want.seg.cnt), 32'(got.seg.cnt));
        check_field("dst_offset", 32'(want.seg.dst), 32'(got.seg.dst));
        check_field("last_segment", 32'(want.last), 32'(got.last));
      end
    end
  end

  // receiver stall pattern, changed every so often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_pattern_t'($urandom_range(0, 4));
      mode_left  <= $urandom_range(30, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      READY_MOSTLY: out_ready <= ($urandom_range(0, 15) != 0);
      default:      out_ready <= mode_left[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] reg_mask(input cfg_idx_t idx);
    case (idx)
      CFG_EQUATOR_WIDTH, CFG_OUT_SPAN, CFG_IN_SPAN: return 32'h7FFF_FFFF;
      CFG_OUT_CENTER, CFG_IN_CENTER:                return 32'h001F_FFFF;
      default:                                      return 32'hFFFF_FFFF;
    endcase
  endfunction

  // one write transfer, then a read transfer of the same register
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_EQUATOR_WIDTH: row_cfg.equator_width_px  = value[30:0];
      CFG_SHIFT:         row_cfg.shift_px          = value;
      CFG_OUT_LEFT:      row_cfg.out_left_px       = value;
      CFG_OUT_SPAN:      row_cfg.out_span_px       = value[30:0];
      CFG_IN_LEFT:       row_cfg.in_left_px        = value;
      CFG_IN_SPAN:       row_cfg.in_span_px        = value[30:0];
      CFG_OUT_CENTER:    row_cfg.out_center_sample = value[20:0];
      default:           row_cfg.in_center_sample  = value[20:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", value & reg_mask(idx), readback & reg_mask(idx));
  endtask

  task automatic apply_settings();
    int i;
    for (i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), cfg_words[i]);
  endtask

  // full-row map: sizes in whole equator pixels, turned into Q23.8
  task automatic build_map_cfg(input int eq_px, input int shift, input int out_half,
                               input int in_half, input int out_ctr, input int in_ctr);
    cfg_words[CFG_EQUATOR_WIDTH] = eq_px * 256;
    cfg_words[CFG_SHIFT]         = shift * 256;
    cfg_words[CFG_OUT_LEFT]      = -out_half * 256;
    cfg_words[CFG_OUT_SPAN]      = 2 * out_half * 256;
    cfg_words[CFG_IN_LEFT]       = -in_half * 256;
    cfg_words[CFG_IN_SPAN]       = 2 * in_half * 256;
    cfg_words[CFG_OUT_CENTER]    = out_ctr;
    cfg_words[CFG_IN_CENTER]     = in_ctr;
  endtask

  task automatic send_row(input logic [16:0] cos_q);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    in_cos_lat <= cos_q;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_for_plans();
    in_valid   <= 1'b0;
    burst_left = 0;
    // let the monitor log the last transfer before looking at the queue
    @(negedge clk);
    while (planned_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_signed(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [16:0] random_cos();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) return 17'($urandom_range(0, 65536));
    if (pick == 8) return 17'($urandom_range(0, 131071));
    case ($urandom_range(0, 3))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd65535;
      default: return 17'd65536;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_row(17'd0);
    send_row(17'd65536);
    send_row(17'd131071);
    wait_for_plans();
  endtask

  task automatic test_wrap_rows();
    build_map_cfg(4096, 1024, 2048, 2048, 2048, 2048);
    apply_settings();
    gaps_on = 1'b0;
    send_row(17'd0);
    send_row(17'd1);
    send_row(17'd4096);
    send_row(17'd32768);
    send_row(17'd49152);
    send_row(17'd65535);
    send_row(17'd65536);
    send_row(17'd131071);
    wait_for_plans();
    // shift the other way so the window wraps off the left edge
    build_map_cfg(4096, -1024, 2048, 2048, 2048, 2048);
    apply_settings();
    gaps_on = 1'b1;
    send_row(17'd65536);
    send_row(17'd20000);
    wait_for_plans();
  endtask

  task automatic test_cover_and_offmap();
    build_map_cfg(2048, 0, 1800, 500, 1800, 1000);
    apply_settings();
    send_row(17'd65536);
    send_row(17'd40000);
    wait_for_plans();
    build_map_cfg(2048, 100, 500, 500, 20000, 1000);
    apply_settings();
    send_row(17'd65536);
    wait_for_plans();
    build_map_cfg(2048, 100, 500, 500, -5000, 1000);
    apply_settings();
    send_row(17'd30000);
    wait_for_plans();
  endtask

  task automatic test_extreme_config();
    cfg_words[CFG_EQUATOR_WIDTH] = 32'h7FFF_FFFF;
    cfg_words[CFG_SHIFT]         = 32'h7FFF_FFFF;
    cfg_words[CFG_OUT_LEFT]      = 32'h7FFF_FFFF;
    cfg_words[CFG_OUT_SPAN]      = 32'h7FFF_FFFF;
    cfg_words[CFG_IN_LEFT]       = 32'h7FFF_FFFF;
    cfg_words[CFG_IN_SPAN]       = 32'h7FFF_FFFF;
    cfg_words[CFG_OUT_CENTER]    = 32'h000F_FFFF;
    cfg_words[CFG_IN_CENTER]     = 32'h000F_FFFF;
    apply_settings();
    send_row(17'd1);
    send_row(17'd65536);
    send_row(17'd131071);
    wait_for_plans();
    cfg_words[CFG_EQUATOR_WIDTH] = 32'h0;
    cfg_words[CFG_SHIFT]         = 32'h8000_0000;
    cfg_words[CFG_OUT_LEFT]      = 32'h8000_0000;
    cfg_words[CFG_OUT_SPAN]      = 32'h0;
    cfg_words[CFG_IN_LEFT]       = 32'h8000_0000;
    cfg_words[CFG_IN_SPAN]       = 32'h0;
    cfg_words[CFG_OUT_CENTER]    = 32'h0010_0000;
    cfg_words[CFG_IN_CENTER]     = 32'h0010_0000;
    apply_settings();
    send_row(17'd0);
    send_row(17'd65536);
    send_row(17'd131071);
    wait_for_plans();
  endtask

  task automatic test_random_rows();
    int phase, eq, in_half, i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      gaps_on = (phase % 3 != 1);
      if (phase % 4 == 3) begin
        for (i = 0; i < 8; i++) cfg_words[i] = $urandom();
      end else begin
        eq      = $urandom_range(16, 8192);
        // a whole-globe input row makes the wrap cases common
        in_half = $urandom_range(0, 1) ? eq / 2 : $urandom_range(1, eq / 2 + 64);
        build_map_cfg(eq, rand_signed(eq), $urandom_range(1, 3000), in_half,
                      int'($urandom_range(0, 4300)) - 100, int'($urandom_range(0, 5000)) - 100);
        cfg_words[CFG_EQUATOR_WIDTH] += $urandom_range(0, 255);
        cfg_words[CFG_SHIFT]         += $urandom_range(0, 255);
        cfg_words[CFG_OUT_SPAN]      += $urandom_range(0, 255);
        cfg_words[CFG_IN_LEFT]       += $urandom_range(0, 255);
      end
      apply_settings();
      repeat (RANDOM_ROWS / RANDOM_PHASES) send_row(random_cos());
      wait_for_plans();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_wrap_rows();
    test_cover_and_offmap();
    test_extreme_config();
    test_random_rows();
    if (errors == 0 && planned_segs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
